FILE: rtl/pss_pkg.sv
// Shared types, constants and register codes for the plucked string synth.
package pss_pkg;

	localparam int SAMPLE_W = 16;
	localparam int PERIOD_W = 12;
	localparam int PITCH_W = 11;
	localparam int GAIN_W = 17;
	localparam int CFG_DATA_W = 17;
	localparam int CFG_IDX_W = 2;

	localparam int BURST_W = 13;
	localparam int BURST_MAX = 4096;

	localparam int DELAY_DEPTH_DEF = 4096;

	// largest negative offset: pitch at its minimum, period at its maximum
	localparam int OFF_NEG = 5119;

	localparam logic [PERIOD_W-1:0] PERIOD_RST = 12'd100;
	localparam logic [PITCH_W-1:0] PITCH_RST = 11'd0;
	localparam logic [GAIN_W-1:0] GAIN_RST = 17'd65535;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PERIOD = 2'd0,
		REG_PITCH = 2'd1,
		REG_GAIN = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] period_length;
		logic [PITCH_W-1:0] pitch_offset;
		logic [GAIN_W-1:0] feedback_gain;
	} cfg_t;

endpackage

FILE: rtl/pss_noise_if.sv
// Stream channel carrying excitation noise samples.
interface pss_noise_if import pss_pkg::*; ();
	logic valid;
	logic ready;
	sample_t noise_sample;

	modport source (output valid, output noise_sample, input ready);
	modport sink (input valid, input noise_sample, output ready);
endinterface

FILE: rtl/pss_string_if.sv
// Stream channel carrying string output samples.
interface pss_string_if import pss_pkg::*; ();
	logic valid;
	logic ready;
	sample_t string_sample;

	modport source (output valid, output string_sample, input ready);
	modport sink (input valid, input string_sample, output ready);
endinterface

FILE: rtl/pss_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module pss_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/pss_offset_unit.sv
// Reduces (pitch_offset - period_length) modulo the delay depth by reciprocal multiplication.
module pss_offset_unit import pss_pkg::*; #(
	parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cfg_t                           cfg,
	input  logic                           start,
	output logic                           busy,
	output logic [$clog2(DELAY_DEPTH)-1:0] offset
);

	localparam int AW = $clog2(DELAY_DEPTH);
	localparam int BIAS = DELAY_DEPTH * ((OFF_NEG + DELAY_DEPTH - 1) / DELAY_DEPTH);
	localparam int X_MAX = BIAS + (1 << (PITCH_W - 1)) - 1;
	localparam int TW = $clog2(X_MAX + 1);
	localparam int RECIP = (1 << TW) / DELAY_DEPTH;

	logic              pend_q;
	logic              mul_q;
	logic              fix_q;
	logic [TW-1:0]     acc_q;
	logic [TW-1:0]     quo_q;
	logic [AW-1:0]     offset_q;
	logic [TW-1:0]     load_val;
	logic [2*TW-1:0]   prod;
	logic [TW-1:0]     rem;

	assign load_val = TW'(BIAS)
		+ {{(TW-PITCH_W){cfg.pitch_offset[PITCH_W-1]}}, cfg.pitch_offset}
		- TW'(cfg.period_length);
	// quotient estimate is exact or one short; one compare and subtract corrects it
	assign prod = acc_q * TW'(RECIP);
	assign rem = acc_q - quo_q * TW'(DELAY_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b1;
			mul_q  <= 1'b0;
			fix_q  <= 1'b0;
		end else if (start) begin
			pend_q <= 1'b1;
			mul_q  <= 1'b0;
			fix_q  <= 1'b0;
		end else begin
			pend_q <= 1'b0;
			mul_q  <= pend_q;
			fix_q  <= mul_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q) begin
			acc_q <= load_val;
		end
		if (mul_q) begin
			quo_q <= prod[2*TW-1:TW];
		end
		if (fix_q) begin
			offset_q <= (rem >= TW'(DELAY_DEPTH)) ? AW'(rem - TW'(DELAY_DEPTH))
				: rem[AW-1:0];
		end
	end

	assign busy = pend_q | mul_q | fix_q;
	assign offset = offset_q;

endmodule

FILE: rtl/pss_out_fifo.sv
// Three-entry result queue in front of the output channel.
module pss_out_fifo import pss_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sample_t       din,
	output logic [1:0]    count,
	pss_string_if.source  voice
);

	localparam int ENTRIES = 3;

	sample_t    mem_q [ENTRIES];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop = voice.valid && voice.ready;
	assign voice.valid = (cnt_q != 2'd0);
	assign voice.string_sample = mem_q[rd_q];
	assign count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == 2'(ENTRIES - 1)) ? 2'd0 : wr_q + 2'd1;
			end
			if (pop) begin
				rd_q <= (rd_q == 2'(ENTRIES - 1)) ? 2'd0 : rd_q + 2'd1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

FILE: rtl/plucked_string_synth_unit.sv
// Top level of the plucked string synth: delay store, feedback loop and channels.
//
//  channel   | dir | payload        | width
//  ----------+-----+----------------+----------------
//  excite    | in  | noise_sample   | 16, signed
//  voice     | out | string_sample  | 16, signed
//  cfg_*     | in  | cfg_data       | 17, index 2 bits
//
// One sample per cycle while excite stays open; a result passes through the delay
// store read register and then the result queue before it reaches voice.
// After reset, and after each write to period_length or pitch_offset, excite is
// held off while the read offset is reduced modulo the depth.
// No clearing pass: store entries not yet written read as zero via a wrap flag.
// Excite stays open while voice stalls until the three-entry result queue fills.
module plucked_string_synth_unit import pss_pkg::*; #(
	parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	pss_noise_if.sink             excite,
	pss_string_if.source          voice
);

	localparam int AW = $clog2(DELAY_DEPTH);

	cfg_t               cfg_q;
	logic               off_start;
	logic               off_busy;
	logic [AW-1:0]      offset;

	logic [AW-1:0]      wp_q;
	logic               wrapped_q;
	logic [BURST_W-1:0] burst_q;
	sample_t            p0_q;
	sample_t            p1_q;
	sample_t            p2_q;

	logic               v_s1;
	sample_t            wr_s1;
	logic               fwd_s1;
	logic               zero_s1;

	logic               accept;
	logic [1:0]         fcnt;
	sample_t            ha;
	sample_t            hb;
	logic [16:0]        sum2;
	sample_t            avg;
	logic signed [33:0] prod;
	logic signed [17:0] fb;
	sample_t            gated;
	logic signed [18:0] total;
	sample_t            written;
	logic [AW:0]        pos_sum;
	logic [AW:0]        pos_wrap;
	logic [AW-1:0]      pos;
	logic [SAMPLE_W-1:0] rdata;
	sample_t            result;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_length <= PERIOD_RST;
			cfg_q.pitch_offset  <= PITCH_RST;
			cfg_q.feedback_gain <= GAIN_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PERIOD: cfg_q.period_length <= cfg_data[PERIOD_W-1:0];
				REG_PITCH:  cfg_q.pitch_offset  <= cfg_data[PITCH_W-1:0];
				REG_GAIN:   cfg_q.feedback_gain <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign off_start = cfg_wr_en && (cfg_reg_t'(cfg_index) == REG_PERIOD
		|| cfg_reg_t'(cfg_index) == REG_PITCH);

	pss_offset_unit #(
		.DELAY_DEPTH (DELAY_DEPTH)
	) u_offset (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.start  (off_start),
		.busy   (off_busy),
		.offset (offset)
	);

	assign excite.ready = !off_busy && (({1'b0, fcnt} + 3'(v_s1)) <= 3'd2);
	assign accept = excite.valid && excite.ready;

	// outputs two and three transfers back, allowing for one result still in the read
	assign ha = v_s1 ? p0_q : p1_q;
	assign hb = v_s1 ? p1_q : p2_q;
	assign sum2 = {ha[SAMPLE_W-1], ha} + {hb[SAMPLE_W-1], hb};
	assign avg = sum2[16:1];
	assign prod = avg * $signed({1'b0, cfg_q.feedback_gain});
	assign fb = prod[33:16];
	assign gated = (burst_q < {1'b0, cfg_q.period_length}) ? excite.noise_sample : '0;
	assign total = {{3{gated[SAMPLE_W-1]}}, gated} + {fb[17], fb};

	always_comb begin
		if (total > 19'sd32767) begin
			written = 16'sh7FFF;
		end else if (total < -19'sd32768) begin
			written = 16'sh8000;
		end else begin
			written = total[SAMPLE_W-1:0];
		end
	end

	assign pos_sum = {1'b0, wp_q} + {1'b0, offset};
	assign pos_wrap = (pos_sum >= (AW+1)'(DELAY_DEPTH)) ? pos_sum - (AW+1)'(DELAY_DEPTH)
		: pos_sum;
	assign pos = pos_wrap[AW-1:0];

	pss_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (DELAY_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (accept),
		.waddr (wp_q),
		.wdata (written),
		.re    (accept),
		.raddr (pos),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
			burst_q   <= '0;
			v_s1      <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (accept) begin
				wp_q <= (wp_q == AW'(DELAY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
				if (wp_q == AW'(DELAY_DEPTH - 1)) begin
					wrapped_q <= 1'b1;
				end
				if (burst_q != BURST_W'(BURST_MAX)) begin
					burst_q <= burst_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wr_s1   <= written;
			fwd_s1  <= (pos == wp_q);
			zero_s1 <= !wrapped_q && (pos > wp_q);
		end
	end

	assign result = fwd_s1 ? wr_s1 : (zero_s1 ? '0 : sample_t'(rdata));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p0_q <= '0;
			p1_q <= '0;
			p2_q <= '0;
		end else if (v_s1) begin
			p0_q <= result;
			p1_q <= p0_q;
			p2_q <= p1_q;
		end
	end

	pss_out_fifo u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (v_s1),
		.din    (result),
		.count  (fcnt),
		.voice  (voice)
	);

endmodule

FILE: tb/pss_voice_checker.sv
`timescale 1ns / 100ps
// Checker for the plucked string synth: predicts each string sample and compares transfers.
module pss_voice_checker import pss_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	pss_noise_if                  excite,
	pss_string_if                 voice,
	output int                    mismatches,
	output int                    outstanding
);

	localparam int LINE_LEN = DELAY_DEPTH_DEF;
	localparam int SAT_HI = 32767;
	localparam int SAT_LO = -32768;

	sample_t                 line_mem [LINE_LEN];
	logic [PERIOD_W-1:0]     head;
	sample_t                 recent [3];
	int unsigned             excite_ticks;
	logic [PERIOD_W-1:0]     period_cfg;
	logic signed [PITCH_W-1:0] pitch_cfg;
	logic [GAIN_W-1:0]       gain_cfg;
	sample_t                 voice_due [$];
	sample_t                 predicted;
	sample_t                 want;
	int                      shown;

	function automatic sample_t pluck_tick(sample_t noise);
		int      gated;
		int      avg;
		int      tap;
		longint  fb;
		longint  total;
		sample_t heard;
		gated = (excite_ticks < period_cfg) ? int'(noise) : 0;
		if (excite_ticks < BURST_MAX) begin
			excite_ticks++;
		end
		avg = (int'(recent[1]) + int'(recent[2])) >>> 1;
		fb = (longint'(avg) * longint'(gain_cfg)) >>> 16;
		total = longint'(gated) + fb;
		if (total > SAT_HI) begin
			total = SAT_HI;
		end else if (total < SAT_LO) begin
			total = SAT_LO;
		end
		line_mem[head] = sample_t'(total);
		// read tap wraps modulo the depth, after this tick's write
		tap = int'(head) - int'(period_cfg) + int'(pitch_cfg);
		heard = line_mem[tap[PERIOD_W-1:0]];
		head = head + 1'b1;
		recent[2] = recent[1];
		recent[1] = recent[0];
		recent[0] = heard;
		return heard;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (line_mem[i]) begin
				line_mem[i] = '0;
			end
			foreach (recent[i]) begin
				recent[i] = '0;
			end
			head = '0;
			excite_ticks = 0;
			period_cfg = PERIOD_RST;
			pitch_cfg = PITCH_RST;
			gain_cfg = GAIN_RST;
			voice_due.delete();
			shown = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_PERIOD: period_cfg = cfg_data[PERIOD_W-1:0];
					REG_PITCH: pitch_cfg = cfg_data[PITCH_W-1:0];
					REG_GAIN: gain_cfg = cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end
			if (excite.valid && excite.ready) begin
				predicted = pluck_tick(excite.noise_sample);
				voice_due = {voice_due, predicted};
			end
			if (voice.valid && voice.ready) begin
				if (voice_due.size() == 0) begin
					mismatches <= mismatches + 1;
					if (shown < 10) begin
						$display("%0t: unexpected voice transfer, got %0d", $time,
							voice.string_sample);
					end
					shown++;
				end else begin
					want = voice_due.pop_front();
					if (voice.string_sample !== want) begin
						mismatches <= mismatches + 1;
						if (shown < 10) begin
							$display("%0t: string_sample expected %0d, got %0d", $time,
								want, voice.string_sample);
						end
						shown++;
					end
				end
			end
			outstanding <= voice_due.size();
		end
	end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the plucked string synth: clock, reset, stimulus and verdict.
module tb_top;
	import pss_pkg::*;

	localparam int ITEM_TARGET = 600;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam sample_t SMP_MAX = 16'sh7FFF;
	localparam sample_t SMP_MIN = 16'sh8000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    outstanding;
	int                    cycles = 0;
	int                    sent = 0;
	bit                    src_idle_on = 1'b1;
	bit                    snk_idle_on = 1'b1;

	pss_noise_if  excite ();
	pss_string_if voice ();

	plucked_string_synth_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.excite    (excite),
		.voice     (voice)
	);

	pss_voice_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.excite      (excite),
		.voice       (voice),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic sample_t draw_noise();
		case ($urandom_range(0, 9))
			0: return SMP_MAX;
			1: return SMP_MIN;
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic push_noise(sample_t v);
		int gap;
		gap = src_idle_on ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			excite.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		excite.valid <= 1'b1;
		excite.noise_sample <= v;
		do @(posedge clk); while (!excite.ready);
		sent++;
	endtask

	// drop valid and wait until every predicted sample has been transferred
	task automatic settle();
		excite.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic program_voice(int period, int pitch, int gain);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom);
		write_reg(REG_PERIOD, {junk[CFG_DATA_W-1:PERIOD_W], PERIOD_W'(period)});
		write_reg(REG_PITCH, {junk[CFG_DATA_W-1:PITCH_W], PITCH_W'(pitch)});
		write_reg(REG_GAIN, GAIN_W'(gain));
		if ($urandom_range(0, 3) == 0) begin
			write_reg(REG_SPARE, CFG_DATA_W'($urandom));
		end
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		int stall;
		voice.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = snk_idle_on ? $urandom_range(0, 17) : 0;
			if (stall > 0) begin
				voice.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			voice.ready <= 1'b1;
			do @(posedge clk); while (!voice.valid);
		end
	end

	initial begin
		int period;
		int pitch;
		int gain;
		int loop_len;
		int n;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_PERIOD;
		cfg_data <= '0;
		excite.valid <= 1'b0;
		excite.noise_sample <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, burst open
		push_noise(SMP_MAX);
		push_noise(SMP_MIN);
		push_noise(draw_noise());

		// zero effective delay with gain above unity: saturation both ways
		settle();
		program_voice(4095, -1, 131071);
		push_noise(SMP_MAX);
		push_noise(SMP_MAX);
		push_noise(SMP_MIN);
		push_noise(SMP_MIN);
		push_noise(16'sh0000);
		push_noise(16'shFFFF);
		push_noise(16'sh5555);
		push_noise(16'shAAAA);

		// short period ends the burst early, zero gain, spare index ignored
		settle();
		write_reg(REG_SPARE, '1);
		program_voice(5, 0, 0);
		repeat (3) push_noise(draw_noise());

		// longer period reopens the burst without a restart
		settle();
		program_voice(1000, 995, 72090);
		repeat (5) push_noise(draw_noise());

		// negative delay and a tap far behind the head
		settle();
		program_voice(0, 1000, 65536);
		repeat (3) push_noise(draw_noise());
		settle();
		program_voice(4095, -1024, 0);
		repeat (3) push_noise(draw_noise());

		while (sent < ITEM_TARGET) begin
			settle();
			loop_len = $urandom_range(0, 40);
			gain = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
				: $urandom_range(60000, 72090);
			case ($urandom_range(0, 3))
				0: begin
					period = $urandom_range(0, 4095);
					pitch = $urandom_range(0, 2047) - 1024;
				end
				1: begin
					pitch = $urandom_range(0, 1023);
					period = pitch + loop_len;
				end
				2: begin
					period = $urandom_range(3072 + loop_len, 4095);
					pitch = period - loop_len - 4096;
				end
				default: begin
					period = $urandom_range(0, 1) ? 4095 : 0;
					case ($urandom_range(0, 2))
						0: pitch = -1024;
						1: pitch = 0;
						default: pitch = 1023;
					endcase
					case ($urandom_range(0, 2))
						0: gain = 0;
						1: gain = 65536;
						default: gain = 131071;
					endcase
				end
			endcase
			program_voice(period, pitch, gain);
			src_idle_on = ($urandom_range(0, 3) != 0);
			snk_idle_on = ($urandom_range(0, 3) != 0);
			n = $urandom_range(20, 80);
			repeat (n) push_noise(draw_noise());
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
